>>> rtl/sfa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the structure factor accumulator.
package sfa_pkg;

  localparam int TABLE_BITS  = 12;
  localparam int MAX_INDEX   = 64;
  localparam int ANGLE_W     = 16;
  localparam int KIDX_W      = 6;
  localparam int LANES       = 4;
  localparam int ACC_W       = 28;
  localparam int TRIG_W      = 15;
  localparam int VAL_W       = 16;
  localparam int OUT_W       = 56;
  localparam int ROM_DEPTH   = 2 ** (TABLE_BITS - 3) + 1;
  localparam int ROM_AW      = $clog2(ROM_DEPTH);
  localparam int ROM_W       = 2 * TRIG_W;
  localparam int QUARTER     = 2 ** (TABLE_BITS - 2);
  localparam int EIGHTH      = QUARTER / 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    REG_K_X = 2'd0,
    REG_K_Y = 2'd1,
    REG_K_Z = 2'd2
  } sfa_reg_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } sfa_quad_e;

  typedef struct packed {
    logic [ANGLE_W-1:0] phase_x;
    logic [ANGLE_W-1:0] phase_y;
    logic [ANGLE_W-1:0] phase_z;
    logic               last;
  } sfa_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] structure_value;
    logic             overflow;
  } sfa_out_t;

  typedef struct packed {
    logic [KIDX_W-1:0] kx;
    logic [KIDX_W-1:0] ky;
    logic [KIDX_W-1:0] kz;
  } sfa_kcfg_t;

  // One angle after classification: quadrant, octant mirror and table address.
  typedef struct packed {
    sfa_quad_e         quad;
    logic              swap;
    logic [ROM_AW-1:0] addr;
  } sfa_lane_t;

  typedef struct packed {
    sfa_lane_t [LANES-1:0] lane;
    logic                  last;
  } sfa_work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sfa_q_status_t;

  typedef logic signed [ACC_W-1:0] sfa_acc_t;

  typedef struct packed {
    sfa_acc_t [LANES-1:0] re;
    sfa_acc_t [LANES-1:0] im;
    logic                 overflow;
  } sfa_snap_t;

endpackage

>>> rtl/sfa_rom.sv
`timescale 1ns / 1ps
// Dual-read octant cos/sin table with registered read data.
module sfa_rom (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [sfa_pkg::ROM_AW-1:0] addr_a_i,
  input  logic [sfa_pkg::ROM_AW-1:0] addr_b_i,
  output logic [sfa_pkg::ROM_W-1:0]  data_a_o,
  output logic [sfa_pkg::ROM_W-1:0]  data_b_o
);
  import sfa_pkg::*;

  localparam logic [63:0] PiQuarterQ60 = 64'h0C90FDAA22168C23;
  localparam int SeriesTerms = 14;
  localparam int StepShift   = 60 - (TABLE_BITS - 3);

  typedef logic [ROM_W-1:0] rom_word_t;
  typedef rom_word_t [ROM_DEPTH-1:0] rom_image_t;

  // (a*b) >> 60, kept to 64 bits
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Taylor series on [0, pi/4], rounded to Q14; word is {cos, sin}
  function automatic rom_word_t octant_word(logic [63:0] x);
    logic [63:0] x2, tc, sc, ts, ss, cr, sr;
    x2 = mul_q60(x, x);
    tc = 64'd1 << 60;
    sc = 64'd1 << 60;
    ts = x;
    ss = x;
    for (int k = 1; k <= SeriesTerms; k++) begin
      tc = mul_q60(tc, x2) / 64'((2 * k - 1) * (2 * k));
      ts = mul_q60(ts, x2) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sc = sc - tc;
        ss = ss - ts;
      end else begin
        sc = sc + tc;
        ss = ss + ts;
      end
    end
    cr = sc + (64'd1 << 45);
    sr = ss + (64'd1 << 45);
    return {cr[46 +: TRIG_W], sr[46 +: TRIG_W]};
  endfunction

  function automatic rom_image_t build_image();
    rom_image_t img;
    for (int r = 0; r < ROM_DEPTH; r++) begin
      img[r] = octant_word(mul_q60(PiQuarterQ60, 64'(r) << StepShift));
    end
    return img;
  endfunction

  localparam rom_image_t RomImage = build_image();

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_o <= RomImage[addr_a_i];
      data_b_o <= RomImage[addr_b_i];
    end
  end

endmodule

>>> rtl/sfa_front.sv
`timescale 1ns / 1ps
// Front end: accepts particles, forms the four angles and classifies them.
module sfa_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sfa_pkg::sfa_in_t       in_data_i,
  input  sfa_pkg::sfa_kcfg_t     kcfg_i,
  input  sfa_pkg::sfa_q_status_t q_status_i,
  output logic                   push_o,
  output sfa_pkg::sfa_work_t     push_data_o
);
  import sfa_pkg::*;

  localparam int ProdW = KIDX_W + ANGLE_W;

  logic               f1_vld_q;
  logic [ANGLE_W-1:0] ax_q, ay_q, az_q;
  logic               last_q;
  logic [ProdW-1:0]   prod_x, prod_y, prod_z;
  logic [ANGLE_W-1:0] ang [LANES];
  logic               accept;

  function automatic sfa_lane_t classify(logic [ANGLE_W-1:0] a);
    logic [TABLE_BITS-1:0] idx;
    logic [ROM_AW-1:0]     r;
    logic [ROM_AW:0]       mirror;
    sfa_lane_t             l;
    idx    = a[ANGLE_W-1 -: TABLE_BITS];
    r      = idx[ROM_AW-1:0];
    mirror = (ROM_AW + 1)'(QUARTER) - {1'b0, r};
    l.quad = sfa_quad_e'(idx[TABLE_BITS-1 -: 2]);
    // past the eighth turn, read the complement angle and swap cos/sin
    if (r <= ROM_AW'(EIGHTH)) begin
      l.swap = 1'b0;
      l.addr = r;
    end else begin
      l.swap = 1'b1;
      l.addr = mirror[ROM_AW-1:0];
    end
    return l;
  endfunction

  assign in_stall_o = f1_vld_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = f1_vld_q && !q_status_i.full;

  assign prod_x = ProdW'(kcfg_i.kx) * ProdW'(in_data_i.phase_x);
  assign prod_y = ProdW'(kcfg_i.ky) * ProdW'(in_data_i.phase_y);
  assign prod_z = ProdW'(kcfg_i.kz) * ProdW'(in_data_i.phase_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (accept) begin
      f1_vld_q <= 1'b1;
    end else if (push_o) begin
      f1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q   <= prod_x[ANGLE_W-1:0];
      ay_q   <= prod_y[ANGLE_W-1:0];
      az_q   <= prod_z[ANGLE_W-1:0];
      last_q <= in_data_i.last;
    end
  end

  always_comb begin
    ang[0] = ax_q + ay_q + az_q;
    ang[1] = ax_q + ay_q - az_q;
    ang[2] = ax_q - ay_q + az_q;
    ang[3] = ax_q - ay_q - az_q;
    for (int l = 0; l < LANES; l++) begin
      push_data_o.lane[l] = classify(ang[l]);
    end
    push_data_o.last = last_q;
  end

endmodule

>>> rtl/sfa_queue.sv
`timescale 1ns / 1ps
// Short queue of classified particles between front end and accumulator.
module sfa_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sfa_pkg::sfa_work_t     push_data_i,
  input  logic                   pop_i,
  output sfa_pkg::sfa_work_t     head_o,
  output sfa_pkg::sfa_q_status_t status_o
);
  import sfa_pkg::*;

  sfa_work_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign status_o.full  = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/sfa_accum.sv
`timescale 1ns / 1ps
// Back end: table lookups and the four saturating complex sums.
module sfa_accum (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  sfa_pkg::sfa_q_status_t q_status_i,
  input  sfa_pkg::sfa_work_t     head_i,
  output logic                   pop_o,
  output logic                   snap_vld_o,
  output sfa_pkg::sfa_snap_t     snap_o
);
  import sfa_pkg::*;

  logic [ROM_W-1:0] rom_data [LANES];
  logic             b1_vld_q, b1_last_q;
  sfa_quad_e        b1_quad_q [LANES];
  logic             b1_swap_q [LANES];

  logic signed [VAL_W-1:0] cval [LANES];
  logic signed [VAL_W-1:0] sval [LANES];
  sfa_acc_t                re_q [LANES];
  sfa_acc_t                im_q [LANES];
  sfa_acc_t                nre  [LANES];
  sfa_acc_t                nim  [LANES];
  logic [LANES-1:0]        ovr, ovi;
  logic                    ov_q, ov_next;
  logic                    snap_vld_q;
  logic                    take;

  // returns {saturated, clamped sum}
  function automatic logic [ACC_W:0] sat_add(sfa_acc_t acc, logic signed [VAL_W-1:0] v);
    logic signed [ACC_W:0] t;
    logic [ACC_W:0]        res;
    t = (ACC_W + 1)'(acc) + (ACC_W + 1)'(v);
    if (t[ACC_W] != t[ACC_W-1]) begin
      res = t[ACC_W] ? {1'b1, 1'b1, {(ACC_W - 1){1'b0}}}
                     : {1'b1, 1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      res = {1'b0, t[ACC_W-1:0]};
    end
    return res;
  endfunction

  assign pop_o = adv_i && !q_status_i.empty;
  assign take  = adv_i && b1_vld_q;

  sfa_rom u_rom_lo (
    .clk_i    (clk_i),
    .en_i     (adv_i),
    .addr_a_i (head_i.lane[0].addr),
    .addr_b_i (head_i.lane[1].addr),
    .data_a_o (rom_data[0]),
    .data_b_o (rom_data[1])
  );

  sfa_rom u_rom_hi (
    .clk_i    (clk_i),
    .en_i     (adv_i),
    .addr_a_i (head_i.lane[2].addr),
    .addr_b_i (head_i.lane[3].addr),
    .data_a_o (rom_data[2]),
    .data_b_o (rom_data[3])
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
    end else if (adv_i) begin
      b1_vld_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b1_last_q <= head_i.last;
      for (int l = 0; l < LANES; l++) begin
        b1_quad_q[l] <= head_i.lane[l].quad;
        b1_swap_q[l] <= head_i.lane[l].swap;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic signed [VAL_W-1:0] pc, ps, cw, sw;
      cw = {1'b0, rom_data[l][ROM_W-1 -: TRIG_W]};
      sw = {1'b0, rom_data[l][TRIG_W-1:0]};
      pc = b1_swap_q[l] ? sw : cw;
      ps = b1_swap_q[l] ? cw : sw;
      case (b1_quad_q[l])
        QUAD_0: begin
          cval[l] = pc;
          sval[l] = ps;
        end
        QUAD_1: begin
          cval[l] = -ps;
          sval[l] = pc;
        end
        QUAD_2: begin
          cval[l] = -pc;
          sval[l] = -ps;
        end
        default: begin
          // fourth quadrant
          cval[l] = ps;
          sval[l] = -pc;
        end
      endcase
      {ovr[l], nre[l]} = sat_add(re_q[l], cval[l]);
      {ovi[l], nim[l]} = sat_add(im_q[l], sval[l]);
    end
    ov_next = ov_q || (|ovr) || (|ovi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LANES; l++) begin
        re_q[l] <= '0;
        im_q[l] <= '0;
      end
      ov_q       <= 1'b0;
      snap_vld_q <= 1'b0;
    end else if (adv_i) begin
      snap_vld_q <= b1_vld_q && b1_last_q;
      if (b1_vld_q) begin
        // end of set: hand the sums on and start over
        for (int l = 0; l < LANES; l++) begin
          re_q[l] <= b1_last_q ? '0 : nre[l];
          im_q[l] <= b1_last_q ? '0 : nim[l];
        end
        ov_q <= b1_last_q ? 1'b0 : ov_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && b1_last_q) begin
      for (int l = 0; l < LANES; l++) begin
        snap_o.re[l] <= nre[l];
        snap_o.im[l] <= nim[l];
      end
      snap_o.overflow <= ov_next;
    end
  end

  assign snap_vld_o = snap_vld_q;

endmodule

>>> rtl/sfa_power.sv
`timescale 1ns / 1ps
// Result pipeline: squared magnitudes, sum, scaling and the output register.
module sfa_power (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               snap_vld_i,
  input  sfa_pkg::sfa_snap_t snap_i,
  input  logic [1:0]         zeros_i,
  output logic               adv_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfa_pkg::sfa_out_t  out_data_o
);
  import sfa_pkg::*;

  localparam int SqW    = 2 * ACC_W;
  localparam int PairW  = SqW + 1;
  localparam int TotalW = SqW + 2;
  localparam logic [1:0] ZerosAll = 2'd3;

  logic                  p1_vld_q, p2_vld_q, p3_vld_q, out_vld_q;
  logic                  p1_ov_q, p2_ov_q, p3_ov_q;
  logic signed [SqW-1:0] sq_re [LANES];
  logic signed [SqW-1:0] sq_im [LANES];
  logic [SqW-1:0]        sq_re_q [LANES];
  logic [SqW-1:0]        sq_im_q [LANES];
  logic [SqW-1:0]        mag_q [LANES];
  logic [PairW-1:0]      pair_q [2];
  logic [TotalW-1:0]     total, scaled;
  logic [OUT_W-1:0]      value;

  assign adv_o       = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sq_re[l] = $signed(snap_i.re[l]) * $signed(snap_i.re[l]);
      sq_im[l] = $signed(snap_i.im[l]) * $signed(snap_i.im[l]);
    end
  end

  assign total  = TotalW'(pair_q[0]) + TotalW'(pair_q[1]);
  assign scaled = total >> zeros_i;

  always_comb begin
    if (zeros_i == ZerosAll) begin
      value = '0;
    end else if (scaled > TotalW'({OUT_W{1'b1}})) begin
      value = '1;
    end else begin
      value = scaled[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv_o) begin
      p1_vld_q  <= snap_vld_i;
      p2_vld_q  <= p1_vld_q;
      p3_vld_q  <= p2_vld_q;
      out_vld_q <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      for (int l = 0; l < LANES; l++) begin
        sq_re_q[l] <= sq_re[l];
        sq_im_q[l] <= sq_im[l];
        mag_q[l]   <= sq_re_q[l] + sq_im_q[l];
      end
      pair_q[0]  <= PairW'(mag_q[0]) + PairW'(mag_q[1]);
      pair_q[1]  <= PairW'(mag_q[2]) + PairW'(mag_q[3]);
      p1_ov_q    <= snap_i.overflow;
      p2_ov_q    <= p1_ov_q;
      p3_ov_q    <= p2_ov_q;
      out_data_o.structure_value <= value;
      out_data_o.overflow        <= p3_ov_q;
    end
  end

endmodule

>>> rtl/structure_factor_accumulator.sv
`timescale 1ns / 1ps
// Top level of the static structure factor accumulator.
// Takes one particle per clock cycle when neither side stalls: the four table
// lookups of a particle are served by two dual-read table copies, so no
// particle waits on another. A four-entry queue separates the front end
// (angle multiply and classification) from the back end (lookup and saturating
// accumulation); the result of a set leaves the snapshot register through a
// squaring and summing pipeline into an output register that holds while
// stalled. An output stall freezes the back end; the front end keeps
// accepting until the queue fills. Write the wave indices only while no
// particle is in flight.
module structure_factor_accumulator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sfa_pkg::sfa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sfa_pkg::sfa_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [sfa_pkg::KIDX_W-1:0] cfg_data_i
);
  import sfa_pkg::*;

  sfa_kcfg_t     kcfg_q;
  sfa_q_status_t q_status;
  sfa_work_t     push_data, head;
  sfa_snap_t     snap;
  logic          push, pop, adv, snap_vld;
  logic [1:0]    zeros;
  logic [KIDX_W-1:0] cfg_value;

  assign cfg_ready_o = 1'b1;
  assign cfg_value   = (cfg_data_i > KIDX_W'(MAX_INDEX - 1)) ? KIDX_W'(MAX_INDEX - 1)
                                                             : cfg_data_i;
  assign zeros = 2'(kcfg_q.kx == '0) + 2'(kcfg_q.ky == '0) + 2'(kcfg_q.kz == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sfa_reg_e'(cfg_index_i))
        REG_K_X: kcfg_q.kx <= cfg_value;
        REG_K_Y: kcfg_q.ky <= cfg_value;
        REG_K_Z: kcfg_q.kz <= cfg_value;
        default: ; // drop writes to unknown registers
      endcase
    end
  end

  sfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .kcfg_i      (kcfg_q),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sfa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  sfa_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .q_status_i (q_status),
    .head_i     (head),
    .pop_o      (pop),
    .snap_vld_o (snap_vld),
    .snap_o     (snap)
  );

  sfa_power u_power (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_vld_i  (snap_vld),
    .snap_i      (snap),
    .zeros_i     (zeros),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/sfa_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the structure factor accumulator, bound to the top.
module sfa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input sfa_pkg::sfa_out_t out_data_o
);
  import sfa_pkg::*;

  // the queue only fills while the output is blocked
  a_stall_needs_blocked_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

  // stall only starts right after a transaction was taken
  a_stall_rises_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without a preceding transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");

  a_out_drop_only_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result withdrawn without a transaction");

endmodule

bind structure_factor_accumulator sfa_checker u_sfa_checker (.*);
